@@ design/sfx_pkg.sv @@
// Shared constants, register codes and walk command/response types for the segment crossfade.
package sfx_pkg;

    localparam int DIGITS    = 4;
    localparam int SEG_COUNT = DIGITS * 8;
    localparam int SEG_AW    = $clog2(SEG_COUNT);
    localparam int WORD_W    = 32;
    localparam int DUTY_W    = 8;
    localparam int CFG_AW    = 2;

    localparam logic [CFG_AW-1:0] REG_PWM_PERIOD  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_STEP_NORMAL = 2'd1;
    localparam logic [CFG_AW-1:0] REG_STEP_EDIT   = 2'd2;

    localparam logic [DUTY_W-1:0] RST_PWM_PERIOD  = 8'd32;
    localparam logic [DUTY_W-1:0] RST_STEP_NORMAL = 8'd8;
    localparam logic [DUTY_W-1:0] RST_STEP_EDIT   = 8'd2;

    localparam logic [SEG_AW-1:0] SEG_LAST = SEG_AW'(SEG_COUNT - 1);

    typedef struct packed {
        logic [DUTY_W-1:0] phase;
        logic [DUTY_W-1:0] period;
        logic              step;
        logic [WORD_W-1:0] target;
    } t_walk_cmd;

    typedef struct packed {
        logic              done;
        logic              moved;
        logic [WORD_W-1:0] pwm_word;
        logic [WORD_W-1:0] final_word;
    } t_walk_rsp;

endpackage

@@ design/sfx_duty_store.sv @@
// Duty level memory: one write port, one registered read port, per-entry valid bits.
module sfx_duty_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [sfx_pkg::SEG_AW-1:0] i_rd_addr,
    output logic [sfx_pkg::DUTY_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [sfx_pkg::SEG_AW-1:0] i_wr_addr,
    input  logic [sfx_pkg::DUTY_W-1:0] i_wr_data
);
    import sfx_pkg::*;

    logic [DUTY_W-1:0]    r_mem [SEG_COUNT];
    logic [SEG_COUNT-1:0] r_vld;
    logic [DUTY_W-1:0]    r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entries read back as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ design/sfx_seg_walk.sv @@
// Walk engine: reads each duty, builds PWM and final words, steps and writes back duties.
module sfx_seg_walk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  sfx_pkg::t_walk_cmd i_cmd,
    output sfx_pkg::t_walk_rsp o_rsp
);
    import sfx_pkg::*;

    logic              r_busy;
    logic [SEG_AW-1:0] r_rd_idx;
    logic              r_proc;
    logic [SEG_AW-1:0] r_proc_idx;
    logic              r_done;
    logic              r_moved;
    logic [WORD_W-1:0] r_pwm_word;
    logic [WORD_W-1:0] r_fin_word;

    logic [DUTY_W-1:0] w_duty;
    logic [WORD_W-1:0] w_mask;
    logic              w_on;
    logic [DUTY_W-1:0] w_goal;
    logic [DUTY_W-1:0] w_new_duty;
    logic              w_move;
    logic              w_wr_en;
    logic [DUTY_W-1:0] w_level;

    sfx_duty_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_busy),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_duty),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_proc_idx),
        .i_wr_data (w_new_duty)
    );

    // segments past the word width have no target bit and stay off
    assign w_mask = WORD_W'(1) << r_proc_idx;
    assign w_on   = |(i_cmd.target & w_mask);
    assign w_goal = w_on ? i_cmd.period : '0;

    always_comb begin
        w_move     = 1'b0;
        w_new_duty = w_duty;
        if (w_duty < w_goal) begin
            w_move     = 1'b1;
            w_new_duty = w_duty + 1'b1;
        end else if (w_duty > w_goal) begin
            w_move     = 1'b1;
            w_new_duty = w_duty - 1'b1;
        end
    end

    assign w_wr_en = r_proc && i_cmd.step && w_move;
    assign w_level = i_cmd.step ? w_new_duty : w_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_idx <= '0;
            r_proc   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_proc <= r_busy;
            r_done <= r_proc && (r_proc_idx == SEG_LAST);
            if (i_go) begin
                r_busy   <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_busy) begin
                if (r_rd_idx == SEG_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc_idx <= r_rd_idx;
        if (i_go) begin
            r_moved    <= 1'b0;
            r_pwm_word <= '0;
            r_fin_word <= '0;
        end else if (r_proc) begin
            r_moved <= r_moved | w_move;
            if (i_cmd.phase < w_duty) begin
                r_pwm_word <= r_pwm_word | w_mask;
            end
            if (w_level >= i_cmd.period) begin
                r_fin_word <= r_fin_word | w_mask;
            end
        end
    end

    assign o_rsp.done       = r_done;
    assign o_rsp.moved      = r_moved;
    assign o_rsp.pwm_word   = r_pwm_word;
    assign o_rsp.final_word = r_fin_word;

endmodule

@@ design/segment_pwm_crossfade.sv @@
// Top level of the segment PWM crossfade: config registers, fade control and result register.
//
// Input channel (i_in_valid / o_in_ready) carries one word per command: action 1
// loads the target mask and arms a fade, action 0 is a timer tick. Starts and
// ticks while no fade is active are absorbed and give no result.
// An active tick walks all SEG_COUNT duty entries through the duty memory, one
// entry per cycle, reading each and, when the step counter runs out, stepping
// it toward its goal and writing it back.
// The tick gives the PWM word; when it ends the fade a second word with the exact
// final on/off pattern follows (o_final_write high), and only that one has o_last.
// Output channel (o_out_valid / i_out_ready) is one result register; a stalled
// receiver holds the word and the next word waits behind it. Input is taken only
// while no tick is being walked or unloaded: an active tick holds the input
// through its walk and the unloading of its words, plus any receiver stall.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
// and belong in idle periods; unknown indexes are dropped.
// Reset (synchronous, active low) restores register defaults, zeroes all duties,
// the target and phase, loads the normal step period and leaves the fade idle.
module segment_pwm_crossfade (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sfx_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [sfx_pkg::DUTY_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    input  logic [sfx_pkg::WORD_W-1:0] i_target_bits,
    input  logic                       i_edit_mode,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [sfx_pkg::WORD_W-1:0] o_segment_bits,
    output logic                       o_final_write,
    output logic                       o_last,
    output logic                       o_fade_active
);
    import sfx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_OUT0 = 2'd2;
    localparam logic [1:0] S_OUT1 = 2'd3;

    logic [1:0]        r_state;
    logic [DUTY_W-1:0] r_pwm_period;
    logic [DUTY_W-1:0] r_step_normal;
    logic [DUTY_W-1:0] r_step_edit;
    logic [WORD_W-1:0] r_target;
    logic [DUTY_W-1:0] r_phase;
    logic [DUTY_W-1:0] r_step_cnt;
    logic              r_active;
    logic              r_do_step;
    logic              r_go;
    logic              r_finished;
    logic [WORD_W-1:0] r_res_pwm;
    logic [WORD_W-1:0] r_res_fin;

    logic [DUTY_W-1:0] n_phase;
    logic [DUTY_W-1:0] n_step_cnt;
    logic [DUTY_W-1:0] w_phase_inc;
    logic [DUTY_W-1:0] w_step_dec;
    logic [DUTY_W-1:0] w_reload;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_out_load;
    t_walk_cmd         w_cmd;
    t_walk_rsp         w_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_out_load = ((r_state == S_OUT0) || (r_state == S_OUT1)) && w_out_free;

    assign w_reload    = i_edit_mode ? r_step_edit : r_step_normal;
    assign w_phase_inc = r_phase + 1'b1;
    assign n_phase     = (w_phase_inc >= r_pwm_period) ? '0 : w_phase_inc;
    assign w_step_dec  = r_step_cnt - 1'b1;
    assign n_step_cnt  = (w_step_dec == '0) ? w_reload : w_step_dec;

    assign w_cmd.phase  = r_phase;
    assign w_cmd.period = r_pwm_period;
    assign w_cmd.step   = r_do_step;
    assign w_cmd.target = r_target;

    sfx_seg_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= RST_PWM_PERIOD;
            r_step_normal <= RST_STEP_NORMAL;
            r_step_edit   <= RST_STEP_EDIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PWM_PERIOD:  r_pwm_period  <= i_cfg_data;
                REG_STEP_NORMAL: r_step_normal <= i_cfg_data;
                REG_STEP_EDIT:   r_step_edit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_phase     <= '0;
            r_step_cnt  <= RST_STEP_NORMAL;
            r_active    <= 1'b0;
            r_do_step   <= 1'b0;
            r_go        <= 1'b0;
            r_finished  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // launch a walk for every active tick
            r_go <= w_in_acc && !i_action && r_active;
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_action) begin
                            r_target   <= i_target_bits;
                            r_step_cnt <= w_reload;
                            r_active   <= 1'b1;
                        end else if (r_active) begin
                            r_phase    <= n_phase;
                            r_step_cnt <= n_step_cnt;
                            r_do_step  <= (w_step_dec == '0);
                            r_state    <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (w_rsp.done) begin
                        r_finished <= r_do_step && !w_rsp.moved;
                        if (r_do_step && !w_rsp.moved) begin
                            r_active <= 1'b0;
                        end
                        r_state <= S_OUT0;
                    end
                end
                S_OUT0: begin
                    if (w_out_free) begin
                        r_state <= r_finished ? S_OUT1 : S_IDLE;
                    end
                end
                S_OUT1: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hold the walk words until both results are unloaded
    always_ff @(posedge i_clk) begin
        if (r_state == S_WALK && w_rsp.done) begin
            r_res_pwm <= w_rsp.pwm_word;
            r_res_fin <= w_rsp.final_word;
        end
        if (r_state == S_OUT0 && w_out_free) begin
            o_segment_bits <= r_res_pwm;
            o_final_write  <= 1'b0;
            o_last         <= !r_finished;
            o_fade_active  <= !r_finished;
        end else if (r_state == S_OUT1 && w_out_free) begin
            o_segment_bits <= r_res_fin;
            o_final_write  <= 1'b1;
            o_last         <= 1'b1;
            o_fade_active  <= 1'b0;
        end
    end

    a_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WALK))
        else $error("walk finished outside of a tick walk");

    a_tick_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_action && r_active) |=> (r_state == S_WALK && r_go))
        else $error("active tick did not launch a walk");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_write) |-> (o_last && !o_fade_active))
        else $error("final word without last or with fade still active");

    // only the PWM word of a tick that ends the fade comes without last
    a_mid_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (!o_fade_active && !o_final_write))
        else $error("non-last word with fade still active or marked final");

endmodule
